// File: rtl/core/bpas_pkg.sv
// Shared constants and types for the band power smoother.
`default_nettype none
package bpas_pkg;
  localparam int unsigned BinWidth  = 24;
  localparam int unsigned BandCount = 128;
  localparam int unsigned BandWidth = $clog2(BandCount);
  localparam int unsigned AccWidth  = 48;
  localparam int unsigned WeightW   = 17;
  localparam int unsigned LevelW    = 17;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam logic [AccWidth-1:0] AccMax = {AccWidth{1'b1}};
  localparam logic [WeightW-1:0] WeightOne = 17'd65536;
  localparam logic [LevelW-1:0] DbFloor = 17'h13800;
  localparam logic [LevelW-1:0] DbCeil = 17'd32767;
  localparam logic [17:0] DbPerLog2 = 18'd197283;

  typedef enum logic [1:0] {
    RegAttack  = 2'd0,
    RegRelease = 2'd1,
    RegShift   = 2'd2
  } reg_idx_e;

  // One classified bin handed from the front to the back part.
  typedef struct packed {
    logic [AccWidth-1:0]  power;
    logic [BandWidth-1:0] band;
    logic                 last;
  } bin_beat_t;

  typedef struct packed {
    logic [15:0] attack;
    logic [15:0] release_c;
    logic [5:0]  shift;
  } cfg_t;
endpackage
`default_nettype wire

// File: rtl/core/band_power_attack_release_smoother.sv
// Non-last bins are taken one per cycle while the back part is idle; each last
// bin holds the back part for smoothing, a 16-step log2 iteration and dB
// scaling, and until its level beat is taken at the output.
// Reset clears the accumulator, marks every band's smoothed power as zero
// through per-band valid bits, and loads register defaults.
// Top level: APB registers and the front, queue and back parts.
`default_nettype none
module band_power_attack_release_smoother import bpas_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // tdata: bin_re[23:0], bin_im[47:24], bin_weight[64:48], band_index[71:65]
  input  wire logic [71:0] s_axis_tdata,
  input  wire logic        s_axis_tlast,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: band_out[6:0], level_db[23:7]
  output      logic [23:0] m_axis_tdata
);
  cfg_t cfg_q;
  logic fv, fr, qv, qr;
  bin_beat_t fb, qb;
  logic [BandWidth-1:0] bo;
  logic [LevelW-1:0] lv;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack <= 16'd58982;
      cfg_q.release_c <= 16'd65208;
      cfg_q.shift <= 6'd24;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        RegAttack:  cfg_q.attack <= pwdata[15:0];
        RegRelease: cfg_q.release_c <= pwdata[15:0];
        RegShift:   cfg_q.shift <= pwdata[5:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[3:2])
      RegAttack:  prdata = {16'd0, cfg_q.attack};
      RegRelease: prdata = {16'd0, cfg_q.release_c};
      RegShift:   prdata = {26'd0, cfg_q.shift};
      default:    prdata = '0;
    endcase
  end

  bpas_front u_front (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .re_i(s_axis_tdata[23:0]), .im_i(s_axis_tdata[47:24]),
    .weight_i(s_axis_tdata[64:48]), .band_i(s_axis_tdata[71:65]),
    .last_i(s_axis_tlast), .cfg_i(cfg_q),
    .out_valid_o(fv), .out_ready_i(fr), .out_beat_o(fb)
  );
  bpas_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(fv), .wr_ready_o(fr), .wr_beat_i(fb),
    .rd_valid_o(qv), .rd_ready_i(qr), .rd_beat_o(qb)
  );
  bpas_back u_back (
    .clk_i, .rst_ni, .in_valid_i(qv), .in_ready_o(qr), .in_beat_i(qb),
    .cfg_i(cfg_q), .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .band_o(bo), .level_o(lv)
  );
  assign m_axis_tdata = {lv, bo};
endmodule
`default_nettype wire

// File: rtl/core/bpas_front.sv
// Front part: magnitude, power, weighting and shifting of each bin, pipelined.
`default_nettype none
module bpas_front import bpas_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_ready_o,
  input  wire logic [BinWidth-1:0]  re_i,
  input  wire logic [BinWidth-1:0]  im_i,
  input  wire logic [WeightW-1:0]   weight_i,
  input  wire logic [BandWidth-1:0] band_i,
  input  wire logic                 last_i,
  input  wire cfg_t                 cfg_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_ready_i,
  output      bin_beat_t            out_beat_o
);
  // Stage 1 registers: squares of magnitudes.
  logic                  s1_valid_q;
  logic [2*BinWidth-1:0] sq_re_q, sq_im_q;
  logic [WeightW-1:0]    w1_q;
  logic [BandWidth-1:0]  b1_q;
  logic                  l1_q;
  // Stage 2 registers: weighted power.
  logic                  s2_valid_q;
  logic [64:0]           t2_q;
  logic [BandWidth-1:0]  b2_q;
  logic                  l2_q;

  logic [BinWidth-1:0] mag_re, mag_im;
  logic [2*BinWidth:0] psum;
  logic [AccWidth-1:0] psat;
  logic [WeightW-1:0]  wsat;
  logic [6:0]          sh;
  logic                adv1, adv2;

  assign adv2 = !s2_valid_q || out_ready_i;
  assign adv1 = !s1_valid_q || adv2;
  assign in_ready_o = adv1;

  always_comb begin
    mag_re = re_i[BinWidth-1] ? (~re_i + 1'b1) : re_i;
    mag_im = im_i[BinWidth-1] ? (~im_i + 1'b1) : im_i;
    psum = {1'b0, sq_re_q} + {1'b0, sq_im_q};
    psat = (psum > {1'b0, AccMax}) ? AccMax : psum[AccWidth-1:0];
    wsat = (w1_q > WeightOne) ? WeightOne : w1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (adv1) s1_valid_q <= in_valid_i;
      if (adv2) s2_valid_q <= s1_valid_q;
    end
  end

  // Payload: squares, then the weight product.
  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      sq_re_q <= mag_re * mag_re;
      sq_im_q <= mag_im * mag_im;
      w1_q <= weight_i;
      b1_q <= band_i;
      l1_q <= last_i;
    end
    if (adv2 && s1_valid_q) begin
      t2_q <= {17'd0, psat} * {48'd0, wsat};
      b2_q <= b1_q;
      l2_q <= l1_q;
    end
  end

  always_comb begin
    logic [64:0] shifted;
    sh = 7'd16 + {1'b0, cfg_i.shift};
    shifted = (sh < 7'd64) ? (t2_q >> sh) : 65'd0;
    out_valid_o = s2_valid_q;
    out_beat_o.power = shifted[AccWidth-1:0];
    out_beat_o.band = b2_q;
    out_beat_o.last = l2_q;
  end
endmodule
`default_nettype wire

// File: rtl/core/bpas_queue.sv
// Short FIFO between front and back parts.
`default_nettype none
module bpas_queue import bpas_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      wr_valid_i,
  output      logic      wr_ready_o,
  input  wire bin_beat_t wr_beat_i,
  output      logic      rd_valid_o,
  input  wire logic      rd_ready_i,
  output      bin_beat_t rd_beat_o
);
  bin_beat_t mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wp_q, rp_q;
  logic [QueuePtrW:0]   cnt_q;
  logic wr, rd;

  assign wr_ready_o = cnt_q != QueueDepth[QueuePtrW:0];
  assign rd_valid_o = cnt_q != '0;
  assign rd_beat_o = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + {{QueuePtrW{1'b0}}, wr} - {{QueuePtrW{1'b0}}, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_beat_i;
  end
endmodule
`default_nettype wire

// File: rtl/core/bpas_back.sv
// Back part: accumulate, smooth the band store, and convert to Q8.8 dB.
`default_nettype none
module bpas_back import bpas_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_ready_o,
  input  wire bin_beat_t            in_beat_i,
  input  wire cfg_t                 cfg_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_ready_i,
  output      logic [BandWidth-1:0] band_o,
  output      logic [LevelW-1:0]    level_o
);
  typedef enum logic [3:0] {
    StIdle, StRead, StOld, StMul, StSum, StNorm, StLog, StDb, StOut
  } state_e;

  state_e st_q;
  logic [AccWidth-1:0]  acc_q, np_q, old_q, s_q;
  logic [BandWidth-1:0] band_q;
  logic [BandCount-1:0] vld_q;
  logic [AccWidth-1:0]  mem_q [BandCount];
  logic [AccWidth-1:0]  rd_q;
  logic [63:0]          pa_q, pb_q;
  logic [5:0]           e_q;
  logic [31:0]          m_q;
  logic [15:0]          frac_q;
  logic [3:0]           it_q;
  logic [40:0]          db_q;
  logic                 zero_q;

  logic [AccWidth:0]   accsum;
  logic [AccWidth-1:0] accsat;
  logic [15:0]         c;
  logic [16:0]         cinv;
  logic [63:0]         ssum;
  logic [5:0]          lead;
  logic [61:0]         msq;
  logic [31:0]         mn;
  logic [21:0]         l2;

  assign in_ready_o = st_q == StIdle;
  assign band_o = band_q;
  assign level_o = zero_q ? DbFloor :
                   ((db_q[40:24] > DbCeil) ? DbCeil : db_q[40:24]);

  always_comb begin
    accsum = {1'b0, acc_q} + {1'b0, in_beat_i.power};
    accsat = accsum[AccWidth] ? AccMax : accsum[AccWidth-1:0];
    c = (np_q > old_q) ? cfg_i.attack : cfg_i.release_c;
    cinv = 17'd65536 - {1'b0, c};
    ssum = pa_q + pb_q;
    lead = '0;
    for (int i = 0; i < AccWidth; i++) begin
      if (s_q[i]) lead = 6'(i);
    end
    msq = {30'd0, m_q} * {30'd0, m_q};
    mn = msq[61:30];
    l2 = {e_q, frac_q};
  end

  // Store read port, registered.
  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[band_q];
    if (st_q == StSum) mem_q[band_q] <= ssum[AccWidth+15:16];
  end

  // Sequencer: accumulate, read, smooth, write back, log2 iteration, dB scaling, output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      acc_q <= '0;
      np_q <= '0;
      old_q <= '0;
      s_q <= '0;
      band_q <= '0;
      vld_q <= '0;
      pa_q <= '0;
      pb_q <= '0;
      e_q <= '0;
      m_q <= '0;
      frac_q <= '0;
      it_q <= '0;
      db_q <= '0;
      zero_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      case (st_q)
        StIdle: begin
          if (in_valid_i) begin
            if (!in_beat_i.last) begin
              acc_q <= accsat;
            end else begin
              acc_q <= '0;
              np_q <= accsat;
              band_q <= in_beat_i.band;
              st_q <= StRead;
            end
          end
        end
        StRead: begin
          st_q <= StOld;
        end
        StOld: begin
          old_q <= vld_q[band_q] ? rd_q : '0;
          st_q <= StMul;
        end
        StMul: begin
          pa_q <= {48'd0, c} * {16'd0, old_q};
          pb_q <= {47'd0, cinv} * {16'd0, np_q};
          st_q <= StSum;
        end
        StSum: begin
          s_q <= ssum[AccWidth+15:16];
          vld_q[band_q] <= 1'b1;
          st_q <= StNorm;
        end
        StNorm: begin
          e_q <= lead;
          zero_q <= s_q == '0;
          m_q <= (lead >= 6'd30) ? 32'(s_q >> (lead - 6'd30))
                                 : 32'(s_q << (6'd30 - lead));
          frac_q <= '0;
          it_q <= '0;
          st_q <= StLog;
        end
        StLog: begin
          if (mn[31]) begin
            m_q <= {1'b0, mn[31:1]};
            frac_q[4'd15 - it_q] <= 1'b1;
          end else begin
            m_q <= mn;
          end
          it_q <= it_q + 1'b1;
          if (it_q == 4'd15) st_q <= StDb;
        end
        StDb: begin
          db_q <= {19'd0, l2} * {23'd0, DbPerLog2} + 41'd8388608;
          out_valid_o <= 1'b1;
          st_q <= StOut;
        end
        StOut: begin
          if (out_ready_i) begin
            out_valid_o <= 1'b0;
            st_q <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/bpas_checker.sv
// Port-level checks for the band power smoother, bound to the top level.
`default_nettype none
module bpas_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        pready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata
);
  a_ready: assert property (@(posedge clk_i) pready) else $error("pready low");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat dropped");
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!m_axis_tdata[23] || m_axis_tdata[23:7] >= 17'h13800))
    else $error("level below floor");
endmodule
bind band_power_attack_release_smoother bpas_checker u_chk (
  .clk_i, .rst_ni, .pready, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire
